### src/bled_pkg.sv
package bled_pkg;

    typedef enum logic [1:0] {
        MODE_DARK    = 2'd0,
        MODE_BREATHE = 2'd1,
        MODE_FREEZE  = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SHORT_PRESS = 2'd0,
        CFG_LONG_PRESS  = 2'd1,
        CFG_RAMP_DIV    = 2'd2
    } cfg_index_t;

    localparam int unsigned PRESS_W = 12;
    localparam int unsigned DIV_W   = 8;
    localparam int unsigned CFG_W   = 12;

    localparam logic [PRESS_W-1:0] SHORT_PRESS_RESET = 12'd117;
    localparam logic [PRESS_W-1:0] LONG_PRESS_RESET  = 12'd2344;
    localparam logic [DIV_W-1:0]   RAMP_DIV_RESET    = 8'd3;
    localparam logic [PRESS_W-1:0] PRESS_MAX         = 12'hFFF;

    // Button events decided on the tick in which the button is released.
    typedef struct packed {
        logic short_press;
        logic long_press;
    } press_evt_t;

endpackage

### src/bled_press.sv
module bled_press (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick_en,
    input  logic                              pressed,
    input  logic [bled_pkg::PRESS_W-1:0]      short_ticks,
    input  logic [bled_pkg::PRESS_W-1:0]      long_ticks,
    output bled_pkg::press_evt_t              evt
);

    logic [bled_pkg::PRESS_W-1:0] len_reg;
    logic [bled_pkg::PRESS_W-1:0] len_next;
    logic                         below_limit;

    // The count saturates one above the long threshold, and never wraps.
    assign below_limit = ({1'b0, len_reg} < ({1'b0, long_ticks} + 13'd1))
                         && (len_reg != bled_pkg::PRESS_MAX);

    always_comb begin
        len_next        = len_reg;
        evt.short_press = 1'b0;
        evt.long_press  = 1'b0;
        if (pressed) begin
            if (below_limit) begin
                len_next = len_reg + 12'd1;
            end
        end else begin
            len_next        = '0;
            evt.short_press = (len_reg >= short_ticks) && (len_reg < long_ticks);
            evt.long_press  = (len_reg >= long_ticks);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (tick_en) begin
            len_reg <= len_next;
        end
    end

endmodule

### src/breathing_led_pwm_with_press_modes.sv
// Breathing LED controller driven by timer ticks. Each transfer on the s_ side is one tick
// carrying the raw button level; each tick gives exactly one result transfer on the m_ side
// with the LED level and the mode after that tick. A tick is worked out in the cycle it is
// taken: the mode, PWM phase, duty, ramp and press counters are updated at the transfer and
// shown directly as the result, so one tick per clock is sustained while m_tready is high,
// and a result held by a stalled m_tready only blocks the next tick until it is taken.
// A short press toggles between breathing and hold (or starts breathing from off); a long
// press switches the block on or off. Thresholds and the ramp divider are written through the
// cfg_ port and should only be changed while no result is waiting.
module breathing_led_pwm_with_press_modes #(
    parameter int unsigned LEVELS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [0] button_pressed
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    // m_tdata: [0] led_on, [2:1] mode_now
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [bled_pkg::CFG_W-1:0]    cfg_data
);

    localparam int unsigned PW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned DW = $clog2(LEVELS + 1);
    localparam logic [PW-1:0] PHASE_LAST = PW'(LEVELS - 1);
    localparam logic [DW-1:0] DUTY_TOP   = DW'(LEVELS);

    logic [bled_pkg::PRESS_W-1:0] short_reg;
    logic [bled_pkg::PRESS_W-1:0] long_reg;
    logic [bled_pkg::DIV_W-1:0]   div_reg;

    bled_pkg::mode_t              mode_reg, mode_next;
    logic [PW-1:0]                phase_reg, phase_next;
    logic [DW-1:0]                duty_reg, duty_next;
    logic [bled_pkg::DIV_W-1:0]   ramp_reg, ramp_next, ramp_inc;
    logic                         falling_reg, falling_next;
    logic                         led_reg, led_next;
    logic                         m_tvalid_reg;

    logic                         tick;
    bled_pkg::press_evt_t         evt;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign tick      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, mode_reg, led_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg <= bled_pkg::SHORT_PRESS_RESET;
            long_reg  <= bled_pkg::LONG_PRESS_RESET;
            div_reg   <= bled_pkg::RAMP_DIV_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bled_pkg::CFG_SHORT_PRESS: short_reg <= cfg_data;
                bled_pkg::CFG_LONG_PRESS:  long_reg  <= cfg_data;
                bled_pkg::CFG_RAMP_DIV:    div_reg   <= cfg_data[bled_pkg::DIV_W-1:0];
                default: ;
            endcase
        end
    end

    bled_press u_press (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick),
        .pressed     (s_tdata[0]),
        .short_ticks (short_reg),
        .long_ticks  (long_reg),
        .evt         (evt)
    );

    assign ramp_inc = ramp_reg + 8'd1;

    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        duty_next    = duty_reg;
        ramp_next    = ramp_reg;
        falling_next = falling_reg;
        led_next     = led_reg;

        // PWM update comes first, using the mode from before this tick.
        if (mode_reg != bled_pkg::MODE_DARK) begin
            led_next = (DW'(phase_reg) < duty_reg);
            if (phase_reg == PHASE_LAST) begin
                phase_next = '0;
                if (mode_reg == bled_pkg::MODE_BREATHE) begin
                    ramp_next = ramp_inc;
                    if (ramp_inc == div_reg) begin
                        ramp_next = '0;
                        // At either end the step only turns the ramp round.
                        if (falling_reg) begin
                            if (duty_reg == '0) begin
                                falling_next = 1'b0;
                            end else begin
                                duty_next = duty_reg - DW'(1);
                            end
                        end else begin
                            if (duty_reg >= DUTY_TOP) begin
                                falling_next = 1'b1;
                            end else begin
                                duty_next = duty_reg + DW'(1);
                            end
                        end
                    end
                end
            end else begin
                phase_next = phase_reg + PW'(1);
            end
        end

        if (evt.short_press) begin
            mode_next = (mode_reg == bled_pkg::MODE_BREATHE) ? bled_pkg::MODE_FREEZE
                                                             : bled_pkg::MODE_BREATHE;
        end else if (evt.long_press) begin
            if (mode_reg == bled_pkg::MODE_DARK) begin
                mode_next = bled_pkg::MODE_BREATHE;
            end else begin
                mode_next    = bled_pkg::MODE_DARK;
                led_next     = 1'b0;
                phase_next   = '0;
                duty_next    = '0;
                ramp_next    = '0;
                falling_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bled_pkg::MODE_DARK;
            phase_reg    <= '0;
            duty_reg     <= '0;
            ramp_reg     <= '0;
            falling_reg  <= 1'b0;
            led_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (tick) begin
                mode_reg    <= mode_next;
                phase_reg   <= phase_next;
                duty_reg    <= duty_next;
                ramp_reg    <= ramp_next;
                falling_reg <= falling_next;
                led_reg     <= led_next;
            end
            if (tick) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/bled_checker.sv
module bled_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // The LED is never lit in a result that reports the block as off.
    a_dark_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:1] == bled_pkg::MODE_DARK)) |-> !m_tdata[0])
        else $error("LED lit while mode is off");

    // With no result waiting the block is always ready to take a tick.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Every tick taken produces a result in the following cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("tick taken without a result");

    // A stalled result keeps its value.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind breathing_led_pwm_with_press_modes bled_checker u_bled_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
